// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FAAP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("faap assertion failed");

// next-cycle implication, disabled during reset
`define FAAP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("faap assertion failed");

`endif

// ===== hw/rtl/faap_pkg.sv =====
// shared types and constants of the auto ack block
package faap_pkg;

  localparam int unsigned AckLen = 13;
  localparam int unsigned IdxW = $clog2(AckLen);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(AckLen - 1);

  localparam logic [2:0] FT_DATA = 3'd1;
  localparam logic [2:0] FT_ACK = 3'd2;
  localparam int unsigned AckReqBit = 5;

  localparam logic [7:0] ACK_FCF_LO = 8'h02;
  localparam logic [7:0] ACK_FCF_HI = 8'h00;
  localparam logic [7:0] ACKED_SEQ_RST = 8'hff;

  typedef enum logic [0:0] {
    CFG_NODE_ADDRESS = 1'b0,
    CFG_IS_ROOT      = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  frame_control;
    logic [7:0]  seq_number;
    logic [63:0] addr_window;
    logic [15:0] tail_window;
    logic [15:0] now_time;
    logic [15:0] cycle_start;
    logic        sending_unicast;
    logic [63:0] expected_receiver;
  } in_t;

  typedef struct packed {
    logic        ack_valid;
    logic [7:0]  ack_byte;
    logic        ack_last;
    logic        target_updated;
    logic [15:0] phase_target;
    logic [7:0]  acked_seq;
  } out_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic        send_ack;
    logic        upd;
    logic [7:0]  seq;
    logic [15:0] phase;
    logic [15:0] phase_target;
    logic [7:0]  acked_seq;
  } job_t;

endpackage

// ===== hw/rtl/frame_auto_ack_with_phase.sv =====
// top level of the 802.15.4 auto ack block with phase report
// usage:
//   input channel in_valid_i / in_ready_o carries one received header or an
//   ack-sent notice per item; output channel out_valid_o / out_ready_i
//   carries one result per handshake.
//   a data frame asking for an ack to this node yields 13 results (one ack
//   byte each, ack_last on the 13th); every other item yields one result.
//   the first result of an item passes through the queue and then the
//   output register before it appears.
//   throughput: one result per cycle while out_ready_i is high, set by the
//   single output register; an ack item takes 13 results, other items one.
//   a two-entry queue lets the front keep taking items while the back is
//   busy or stalled; in_ready_o falls only when that queue is full.
//   when the receiver holds out_ready_i low the current result stays put
//   and the back end waits.
//   reset clears the queue and output, node_address and is_root to zero,
//   the phase target to zero and the acked sequence number to 0xff.
//   config writes via cfg_we_i / cfg_idx_i / cfg_data_i take effect at once
//   and are meant for idle periods only.
module frame_auto_ack_with_phase (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [63:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  faap_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output faap_pkg::out_t  out_data_o
);
  import faap_pkg::*;

  job_t        push_job;
  job_t        head_job;
  logic        push;
  logic        pop;
  logic        full;
  logic        head_valid;
  logic [63:0] node_address;

  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;

  faap_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push),
    .item_i         (in_data_i),
    .job_o          (push_job),
    .node_address_o (node_address)
  );

  faap_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  faap_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (head_valid),
    .job_i          (head_job),
    .node_address_i (node_address),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

// ===== hw/rtl/faap_front.sv =====
// front end: config registers, item classification and state updates
module faap_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               push_i,
  input  faap_pkg::in_t      item_i,
  output faap_pkg::job_t     job_o,
  output logic [63:0]        node_address_o
);
  import faap_pkg::*;

  logic [63:0] node_address_q;
  logic        is_root_q;
  logic [15:0] target_q, target_d;
  logic [7:0]  acked_q, acked_d;
  logic [63:0] swapped;
  logic [63:0] dest;
  logic [15:0] diff;
  logic [2:0]  ftype;
  logic        upd;
  logic        send_ack;
  logic [15:0] phase;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      swapped[63-8*i -: 8] = item_i.addr_window[8*i +: 8];
    end
  end

  assign dest  = {item_i.tail_window, item_i.addr_window[63:16]};
  assign ftype = item_i.frame_control[2:0];
  assign diff  = item_i.cycle_start - item_i.now_time;

  always_comb begin
    target_d = target_q;
    acked_d  = acked_q;
    upd      = 1'b0;
    send_ack = 1'b0;
    phase    = '0;
    if (!is_root_q && diff[15]) begin
      phase = item_i.now_time - item_i.cycle_start;
    end
    if (item_i.command) begin
      acked_d = item_i.seq_number;
    end else if (ftype == FT_ACK && item_i.sending_unicast) begin
      if (swapped == item_i.expected_receiver) begin
        upd      = 1'b1;
        target_d = item_i.tail_window;
      end
    end else if (ftype == FT_DATA && item_i.frame_control[AckReqBit]
                 && dest == node_address_q) begin
      send_ack = 1'b1;
    end
  end

  assign job_o.send_ack     = send_ack;
  assign job_o.upd          = upd;
  assign job_o.seq          = item_i.seq_number;
  assign job_o.phase        = phase;
  assign job_o.phase_target = target_d;
  assign job_o.acked_seq    = acked_d;
  assign node_address_o     = node_address_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= '0;
      is_root_q      <= 1'b0;
      target_q       <= '0;
      acked_q        <= ACKED_SEQ_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NODE_ADDRESS: node_address_q <= cfg_data_i;
          CFG_IS_ROOT:      is_root_q      <= cfg_data_i[0];
          default:          ;
        endcase
      end
      if (push_i) begin
        target_q <= target_d;
        acked_q  <= acked_d;
      end
    end
  end

endmodule

// ===== hw/rtl/faap_queue.sv =====
// two-entry queue between the front and the back
module faap_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  faap_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output faap_pkg::job_t  job_o
);
  import faap_pkg::*;

  job_t       mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/faap_back.sv =====
// back end: emits results of queued items through an output register
module faap_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  faap_pkg::job_t  job_i,
  input  logic [63:0]     node_address_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output faap_pkg::out_t  out_data_o
);
  import faap_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q;
  out_t            res;
  logic            adv;
  logic            last;
  logic [7:0]      byte_sel;
  logic [2:0]      nsel;

  assign adv  = !out_valid_q || out_ready_i;
  assign last = !job_i.send_ack || (idx_q == IdxLast);
  assign nsel = 3'(idx_q - IdxW'(3));

  always_comb begin
    case (idx_q) inside
      IdxW'(0):             byte_sel = ACK_FCF_LO;
      IdxW'(1):             byte_sel = ACK_FCF_HI;
      IdxW'(2):             byte_sel = job_i.seq;
      [IdxW'(3):IdxW'(10)]: byte_sel = node_address_i[8*(3'd7 - nsel) +: 8];
      IdxW'(11):            byte_sel = job_i.phase[7:0];
      IdxW'(12):            byte_sel = job_i.phase[15:8];
      default:              byte_sel = '0;
    endcase
  end

  always_comb begin
    res.ack_valid      = job_i.send_ack;
    res.ack_byte       = job_i.send_ack ? byte_sel : 8'h00;
    res.ack_last       = last;
    res.target_updated = job_i.upd;
    res.phase_target   = job_i.phase_target;
    res.acked_seq      = job_i.acked_seq;
  end

  assign pop_o = adv && job_valid_i && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = job_valid_i;
      if (job_valid_i) begin
        idx_d = last ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && job_valid_i) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/faap_checker.sv =====
// port-level assertions for the auto ack block and their bind
`include "assert_macros.svh"

module faap_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input faap_pkg::out_t  out_data_o
);
  import faap_pkg::*;

  logic stall;
  logic mid_ack;

  assign stall   = out_valid_o && !out_ready_i;
  assign mid_ack = out_valid_o && out_ready_i && out_data_o.ack_valid
                   && !out_data_o.ack_last;

  `FAAP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stall,
                   out_valid_o && $stable(out_data_o))
  `FAAP_ASSERT_NOW(a_only_ack_continues, clk_i, rst_ni,
                   out_valid_o && !out_data_o.ack_last, out_data_o.ack_valid)
  `FAAP_ASSERT_NOW(a_update_single, clk_i, rst_ni,
                   out_valid_o && out_data_o.target_updated,
                   !out_data_o.ack_valid && out_data_o.ack_last)
  `FAAP_ASSERT_NXT(a_ack_no_gap, clk_i, rst_ni, mid_ack,
                   out_valid_o && out_data_o.ack_valid)

endmodule

bind frame_auto_ack_with_phase faap_checker u_faap_checker (.*);
